/* sv/polar_unwrap_bilinear_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polar unwrap unit
// Shared property templates, sampled on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLAR_UNWRAP_BILINEAR_UNIT_MACROS_SVH
`define POLAR_UNWRAP_BILINEAR_UNIT_MACROS_SVH

// same-cycle implication
`define PUB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PUB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pub_pkg.sv */
// ----------------------------------------------------------------------------
// pub_pkg
// Types, widths, sine table builder and helpers of the polar unwrap unit.
// ----------------------------------------------------------------------------
package pub_pkg;

	localparam int RADIUS_CAP = 256;
	localparam int FB         = 12;
	localparam int RAD_W      = 9;
	localparam int COORD_W    = 9;
	localparam int DIV_W      = RAD_W + 1;
	localparam int RECIP_W    = 21;
	localparam int RECIP_LO_W = 11;
	localparam int N2_W       = 21;
	localparam int PH_W       = 12;
	localparam int SINE_W     = FB + 1;
	localparam int SINE_LEN   = 1025;
	localparam int SINE_AW    = 11;
	localparam int RO_W       = RAD_W + 1;
	localparam int TRIG_W     = FB + 2;
	localparam int V_W        = 24;
	localparam int PIX_W      = 24;
	localparam int BANK_AW    = 2 * (COORD_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int W_W        = 2 * FB + 1;
	localparam int RC_CNT_W   = 5;
	localparam int RC_STEPS   = RECIP_W;

	localparam int     Q_SH        = 30;
	localparam longint HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_LEN];

	typedef enum logic {
		RC_IDLE,
		RC_RUN
	} rc_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] src_row;
		logic [COORD_W-1:0] src_col;
		logic [PIX_W-1:0]   pix;
	} load_t;

	typedef struct packed {
		logic                   op;
		load_t                  load;
		logic signed [RO_W-1:0] r;
		logic [PH_W-1:0]        p;
	} geo_in_t;

	typedef struct packed {
		logic               op;
		load_t              load;
		logic               nvalid;
		logic               bvalid;
		logic [COORD_W-1:0] nr;
		logic [COORD_W-1:0] nc;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [FB-1:0]      dx;
		logic [FB-1:0]      dy;
	} store_in_t;

	typedef struct packed {
		logic                  nvalid;
		logic                  bvalid;
		logic                  cx0;
		logic                  cy0;
		logic                  nr0;
		logic                  nc0;
		logic [FB-1:0]         dx;
		logic [FB-1:0]         dy;
		logic [3:0][PIX_W-1:0] rda;
		logic [3:0][PIX_W-1:0] rdb;
	} blend_in_t;

	typedef struct packed {
		logic             nvalid;
		logic             bvalid;
		logic [PIX_W-1:0] near_pix;
		logic [PIX_W-1:0] bilin_pix;
	} result_t;

	function automatic logic [RAD_W-1:0] eff_radius(input logic [RAD_W-1:0] v);
		logic [RAD_W-1:0] e;
		e = v;
		if (v == '0)
			e = RAD_W'(1);
		else if (v > RAD_W'(RADIUS_CAP))
			e = RAD_W'(RADIUS_CAP);
		return e;
	endfunction

	// magnitude of the next series term before the factorial step, m * x^2 in Q30
	function automatic longint taylor_next(input longint m, input longint x);
		longint u;
		u = (m * x) >>> Q_SH;
		return (u * x) >>> Q_SH;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		longint    x;
		longint    m;
		longint    sum;
		int        k;
		for (k = 0; k < SINE_LEN; k++) begin
			x = (longint'(k) * HALF_PI_Q30) >>> 10;
			m = taylor_next(x, x) / 64'sd6;
			sum = x - m;
			m = taylor_next(m, x) / 64'sd20;
			sum += m;
			m = taylor_next(m, x) / 64'sd42;
			sum -= m;
			m = taylor_next(m, x) / 64'sd72;
			sum += m;
			m = taylor_next(m, x) / 64'sd110;
			sum -= m;
			m = taylor_next(m, x) / 64'sd156;
			sum += m;
			m = taylor_next(m, x) / 64'sd210;
			sum -= m;
			if (sum < 0)
				sum = 0;
			sum = (sum + (longint'(1) << (29 - FB))) >>> (30 - FB);
			if (sum > (longint'(1) << FB))
				sum = longint'(1) << FB;
			t[k] = SINE_W'(sum);
		end
		return t;
	endfunction

endpackage

/* sv/polar_unwrap_bilinear_unit.sv */
// ----------------------------------------------------------------------------
// polar_unwrap_bilinear_unit
// Fisheye-to-panorama remap: frame store loads and per-pixel sample queries.
// ----------------------------------------------------------------------------
// One beat enters per clock, loads and queries alike, unless back-pressure or
// the busy reciprocal holds the input; a query returns one result beat, a load
// returns nothing. The rate is set by the frame store, four parity banks with
// two read ports each, which serve all five pixel reads of a query in the same
// cycle. A ring_radius write starts a bit-serial reciprocal; while it runs
// s_axis_tready is low. Out of reset the reciprocal for radius 256 is ready at once.
module polar_unwrap_bilinear_unit import pub_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ring_radius_we,
	input  logic [RAD_W-1:0] ring_radius_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// src_row, src_col, in_red, in_green, in_blue, out_row, out_col, zero pad
	input  logic [63:0]      s_axis_tdata,
	// op
	input  logic [0:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// near_red, near_green, near_blue, bilin_red, bilin_green, bilin_blue
	output logic [47:0]      m_axis_tdata,
	// near_valid, bilin_valid
	output logic [1:0]       m_axis_tuser
);

`include "polar_unwrap_bilinear_unit_macros.svh"

	logic [RAD_W-1:0]   ring_q;
	logic [RAD_W-1:0]   radius;
	logic               busy;
	logic [RECIP_W-1:0] recip;
	load_t              ld;

	logic               ph_ready, ph_valid, ge_ready, ge_valid;
	logic               st_ready, st_valid, bl_ready;
	geo_in_t            ph_item;
	store_in_t          ge_item;
	blend_in_t          st_item;
	result_t            res;
	logic               near_clear, bilin_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ring_q <= RAD_W'(RADIUS_CAP);
		else if (ring_radius_we)
			ring_q <= ring_radius_wdata;
	end

	assign radius = eff_radius(ring_q);

	pub_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ring_radius_we),
		.divisor ({eff_radius(ring_radius_wdata), 1'b0}),
		.busy    (busy),
		.recip   (recip)
	);

	assign ld.src_row = s_axis_tdata[8:0];
	assign ld.src_col = s_axis_tdata[17:9];
	assign ld.pix     = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};

	assign s_axis_tready = ph_ready && !busy;

	pub_phase u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid && !busy),
		.in_ready   (ph_ready),
		.in_op      (s_axis_tuser[0]),
		.in_load    (ld),
		.in_out_row (s_axis_tdata[49:42]),
		.in_out_col (s_axis_tdata[59:50]),
		.radius     (radius),
		.recip      (recip),
		.out_valid  (ph_valid),
		.out_ready  (ge_ready),
		.out_item   (ph_item)
	);

	pub_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ph_valid),
		.in_ready  (ge_ready),
		.in_item   (ph_item),
		.radius    (radius),
		.out_valid (ge_valid),
		.out_ready (st_ready),
		.out_item  (ge_item)
	);

	pub_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ge_valid),
		.in_ready  (st_ready),
		.in_item   (ge_item),
		.out_valid (st_valid),
		.out_ready (bl_ready),
		.out_item  (st_item)
	);

	pub_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid),
		.in_ready  (bl_ready),
		.in_item   (st_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (res)
	);

	assign m_axis_tdata = {res.bilin_pix[7:0], res.bilin_pix[15:8], res.bilin_pix[23:16],
	                       res.near_pix[7:0], res.near_pix[15:8], res.near_pix[23:16]};
	assign m_axis_tuser = {res.bvalid, res.nvalid};

	assign near_clear  = m_axis_tuser[0] || (m_axis_tdata[23:0] == '0);
	assign bilin_clear = m_axis_tuser[1] || (m_axis_tdata[47:24] == '0);

	`PUB_ASSERT_NEXT(a_cfg_holds_input, ring_radius_we, !s_axis_tready, "input open after write")
	`PUB_ASSERT_IMPLY(a_near_zero, m_axis_tvalid, near_clear, "nearest color set while invalid")
	`PUB_ASSERT_IMPLY(a_bilin_zero, m_axis_tvalid, bilin_clear, "bilinear color set while invalid")

endmodule

/* sv/pub_recip.sv */
// ----------------------------------------------------------------------------
// pub_recip
// Bit-serial reciprocal floor(2^21 / divisor), rerun on every radius write.
// ----------------------------------------------------------------------------
module pub_recip import pub_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   divisor,
	output logic               busy,
	output logic [RECIP_W-1:0] recip
);

	rc_state_t             state_q, state_d;
	logic [RC_CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]      div_q;
	logic [DIV_W-1:0]      rem_q;
	logic [RECIP_W:0]      quo_q;
	logic [DIV_W:0]        trial;
	logic                  ge;
	logic [DIV_W-1:0]      rem_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= RC_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			RC_IDLE: begin
				if (start)
					state_d = RC_RUN;
			end
			RC_RUN: begin
				busy = 1'b1;
				if (!start && cnt_q == '0)
					state_d = RC_IDLE;
			end
			default: state_d = RC_IDLE;
		endcase
	end

	assign trial = {rem_q, (cnt_q == RC_CNT_W'(RC_STEPS))};
	assign ge    = trial >= {1'b0, div_q};
	assign rem_d = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			div_q <= DIV_W'(2 * RADIUS_CAP);
			rem_q <= '0;
			quo_q <= (RECIP_W + 1)'(1 << FB);
		end else if (start) begin
			cnt_q <= RC_CNT_W'(RC_STEPS);
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == RC_RUN) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= rem_d;
			quo_q <= {quo_q[RECIP_W-1:0], ge};
		end
	end

	assign recip = quo_q[RECIP_W-1:0];

endmodule

/* sv/pub_phase.sv */
// ----------------------------------------------------------------------------
// pub_phase
// Stages 1-5: ring offset and angle phase round(col*1024/R) mod 4096.
// ----------------------------------------------------------------------------
module pub_phase import pub_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_op,
	input  load_t              in_load,
	input  logic [7:0]         in_out_row,
	input  logic [9:0]         in_out_col,
	input  logic [RAD_W-1:0]   radius,
	input  logic [RECIP_W-1:0] recip,
	output logic               out_valid,
	input  logic               out_ready,
	output geo_in_t            out_item
);

	logic [5:1] v_q;
	logic [6:1] en;

	logic                   op_s1, op_s2, op_s3, op_s4, op_s5;
	load_t                  ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic signed [RO_W-1:0] r_s1, r_s2, r_s3, r_s4, r_s5;
	logic [N2_W-1:0]        n2_s1, n2_s2, n2_s3, n2_s4;
	logic [31:0]            plo_s2;
	logic [30:0]            phi_s2;
	logic [N2_W-1:0]        q0_s3, q0_s4;
	logic [N2_W:0]          prod_s4;
	logic [PH_W-1:0]        p_s5;

	logic [DIV_W-1:0]       dvs;
	logic [2*N2_W-1:0]      acc;
	logic [N2_W:0]          rem;

	assign dvs = {radius, 1'b0};

	always_comb begin
		en[6] = out_ready;
		for (int k = 5; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
			if (en[4]) v_q[4] <= v_q[3];
			if (en[5]) v_q[5] <= v_q[4];
		end
	end

	assign acc = {phi_s2, 11'b0} + (2 * N2_W)'(plo_s2);
	assign rem = {1'b0, n2_s4} - prod_s4;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1 <= in_op;
			ld_s1 <= in_load;
			r_s1  <= $signed({1'b0, radius}) - $signed({2'b00, in_out_row});
			n2_s1 <= {in_out_col, 11'b0} + N2_W'(radius);
		end
		if (en[2]) begin
			op_s2  <= op_s1;
			ld_s2  <= ld_s1;
			r_s2   <= r_s1;
			n2_s2  <= n2_s1;
			plo_s2 <= 32'(n2_s1) * 32'(recip[RECIP_LO_W-1:0]);
			phi_s2 <= 31'(n2_s1) * 31'(recip[RECIP_W-1:RECIP_LO_W]);
		end
		if (en[3]) begin
			op_s3 <= op_s2;
			ld_s3 <= ld_s2;
			r_s3  <= r_s2;
			n2_s3 <= n2_s2;
			q0_s3 <= acc[2*N2_W-1:N2_W];
		end
		if (en[4]) begin
			op_s4   <= op_s3;
			ld_s4   <= ld_s3;
			r_s4    <= r_s3;
			n2_s4   <= n2_s3;
			q0_s4   <= q0_s3;
			prod_s4 <= (N2_W + 1)'(31'(q0_s3) * 31'(dvs));
		end
		if (en[5]) begin
			op_s5 <= op_s4;
			ld_s5 <= ld_s4;
			r_s5  <= r_s4;
			p_s5  <= (rem >= (N2_W + 1)'(dvs)) ? q0_s4[PH_W-1:0] + 1'b1
			                                    : q0_s4[PH_W-1:0];
		end
	end

	assign out_valid     = v_q[5];
	assign out_item.op   = op_s5;
	assign out_item.load = ld_s5;
	assign out_item.r    = r_s5;
	assign out_item.p    = p_s5;

endmodule

/* sv/pub_geom.sv */
// ----------------------------------------------------------------------------
// pub_geom
// Stages 6-8: sine/cosine lookup, polar scaling, source coordinates and
// range checks for the nearest and bilinear samples.
// ----------------------------------------------------------------------------
module pub_geom import pub_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  geo_in_t          in_item,
	input  logic [RAD_W-1:0] radius,
	output logic             out_valid,
	input  logic             out_ready,
	output store_in_t        out_item
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	logic [3:1] v_q;
	logic [4:1] en;

	logic                   op_s6, op_s7, op_s8;
	load_t                  ld_s6, ld_s7, ld_s8;
	logic signed [RO_W-1:0] r_s6;
	logic [SINE_W-1:0]      cmag_s6, smag_s6;
	logic                   cneg_s6, sneg_s6;
	logic signed [V_W-1:0]  vx_s7, vy_s7;
	logic                   nv_s8, bv_s8;
	logic [COORD_W-1:0]     nr_s8, nc_s8, cx_s8, cy_s8;
	logic [FB-1:0]          dx_s8, dy_s8;

	logic [PH_W-1:0]        pc;
	logic [SINE_AW-1:0]     ca, sa;
	logic signed [TRIG_W-1:0] cs, sn;
	logic [DIV_W-1:0]       dvs;
	logic signed [22:0]     fx, fy;
	logic [11:0]            cx_up, cy_up;
	logic [V_W-1:0]         ax, ay;
	logic [11:0]            tx, ty;
	logic signed [12:0]     rx, ry, nr, nc;

	assign pc = in_item.p + PH_W'(1024);
	assign sa = in_item.p[10] ? SINE_AW'(11'd1024 - {1'b0, in_item.p[9:0]})
	                          : {1'b0, in_item.p[9:0]};
	assign ca = pc[10] ? SINE_AW'(11'd1024 - {1'b0, pc[9:0]}) : {1'b0, pc[9:0]};

	assign cs = cneg_s6 ? -$signed({1'b0, cmag_s6}) : $signed({1'b0, cmag_s6});
	assign sn = sneg_s6 ? -$signed({1'b0, smag_s6}) : $signed({1'b0, smag_s6});

	assign dvs   = {radius, 1'b0};
	assign fx    = $signed({2'b00, radius, 12'b0}) + 23'(vx_s7);
	assign fy    = $signed({2'b00, radius, 12'b0}) + 23'(vy_s7);
	assign cx_up = {1'b0, fx[22:12]} + 12'(fx[FB-1:0] != '0);
	assign cy_up = {1'b0, fy[22:12]} + 12'(fy[FB-1:0] != '0);

	assign ax = vx_s7[V_W-1] ? V_W'(-vx_s7) : V_W'(vx_s7);
	assign ay = vy_s7[V_W-1] ? V_W'(-vy_s7) : V_W'(vy_s7);
	assign tx = 12'((ax + V_W'(2048)) >> FB);
	assign ty = 12'((ay + V_W'(2048)) >> FB);
	assign rx = vx_s7[V_W-1] ? -$signed({1'b0, tx}) : $signed({1'b0, tx});
	assign ry = vy_s7[V_W-1] ? -$signed({1'b0, ty}) : $signed({1'b0, ty});
	assign nr = $signed({4'b0, radius}) + rx;
	assign nc = $signed({4'b0, radius}) + ry;

	always_comb begin
		en[4] = out_ready;
		for (int k = 3; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s6   <= in_item.op;
			ld_s6   <= in_item.load;
			r_s6    <= in_item.r;
			smag_s6 <= SINE_ROM[sa];
			cmag_s6 <= SINE_ROM[ca];
			sneg_s6 <= in_item.p[11];
			cneg_s6 <= pc[11];
		end
		if (en[2]) begin
			op_s7 <= op_s6;
			ld_s7 <= ld_s6;
			vx_s7 <= V_W'(r_s6) * V_W'(cs);
			vy_s7 <= V_W'(r_s6) * V_W'(sn);
		end
		if (en[3]) begin
			op_s8 <= op_s7;
			ld_s8 <= ld_s7;
			nv_s8 <= !nr[12] && !nc[12] && (nr[11:0] < 12'(dvs)) && (nc[11:0] < 12'(dvs));
			bv_s8 <= !fx[22] && !fy[22] && (cx_up < 12'(dvs)) && (cy_up < 12'(dvs));
			nr_s8 <= nr[COORD_W-1:0];
			nc_s8 <= nc[COORD_W-1:0];
			cx_s8 <= fx[FB+COORD_W-1:FB];
			cy_s8 <= fy[FB+COORD_W-1:FB];
			dx_s8 <= fx[FB-1:0];
			dy_s8 <= fy[FB-1:0];
		end
	end

	assign out_valid       = v_q[3];
	assign out_item.op     = op_s8;
	assign out_item.load   = ld_s8;
	assign out_item.nvalid = nv_s8;
	assign out_item.bvalid = bv_s8;
	assign out_item.nr     = nr_s8;
	assign out_item.nc     = nc_s8;
	assign out_item.cx     = cx_s8;
	assign out_item.cy     = cy_s8;
	assign out_item.dx     = dx_s8;
	assign out_item.dy     = dy_s8;

endmodule

/* sv/pub_store.sv */
// ----------------------------------------------------------------------------
// pub_store
// Stage 9: frame store split in four banks by row and column parity, so the
// four bilinear neighbors fall in different banks. Each bank has one write
// and two read ports: port A for the bilinear neighbor, port B for nearest.
// ----------------------------------------------------------------------------
module pub_store import pub_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  store_in_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output blend_in_t out_item
);

	logic                  v_q;
	logic                  en;
	logic [3:0][PIX_W-1:0] rda_s9, rdb_s9;
	logic                  nv_s9, bv_s9, cx0_s9, cy0_s9, nr0_s9, nc0_s9;
	logic [FB-1:0]         dx_s9, dy_s9;

	logic [COORD_W-1:0]    cx1, cy1;
	logic [BANK_AW-1:0]    waddr, baddr;
	logic [1:0]            wsel;
	logic                  wr;

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	assign cx1   = in_item.cx + 1'b1;
	assign cy1   = in_item.cy + 1'b1;
	assign wr    = en && in_valid && !in_item.op;
	assign wsel  = {in_item.load.src_row[0], in_item.load.src_col[0]};
	assign waddr = {in_item.load.src_row[COORD_W-1:1], in_item.load.src_col[COORD_W-1:1]};
	assign baddr = {in_item.nr[COORD_W-1:1], in_item.nc[COORD_W-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [PIX_W-1:0]   mem [BANK_DEPTH];
		logic [COORD_W-1:0] row_b, col_b;
		logic [BANK_AW-1:0] aaddr;

		assign row_b = (in_item.cx[0] == 1'(b >> 1)) ? in_item.cx : cx1;
		assign col_b = (in_item.cy[0] == 1'(b & 1)) ? in_item.cy : cy1;
		assign aaddr = {row_b[COORD_W-1:1], col_b[COORD_W-1:1]};

		always_ff @(posedge clk) begin
			if (wr && wsel == 2'(b))
				mem[waddr] <= in_item.load.pix;
			if (en) begin
				rda_s9[b] <= mem[aaddr];
				rdb_s9[b] <= mem[baddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= in_valid && in_item.op;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nv_s9  <= in_item.nvalid;
			bv_s9  <= in_item.bvalid;
			cx0_s9 <= in_item.cx[0];
			cy0_s9 <= in_item.cy[0];
			nr0_s9 <= in_item.nr[0];
			nc0_s9 <= in_item.nc[0];
			dx_s9  <= in_item.dx;
			dy_s9  <= in_item.dy;
		end
	end

	assign out_valid       = v_q;
	assign out_item.nvalid = nv_s9;
	assign out_item.bvalid = bv_s9;
	assign out_item.cx0    = cx0_s9;
	assign out_item.cy0    = cy0_s9;
	assign out_item.nr0    = nr0_s9;
	assign out_item.nc0    = nc0_s9;
	assign out_item.dx     = dx_s9;
	assign out_item.dy     = dy_s9;
	assign out_item.rda    = rda_s9;
	assign out_item.rdb    = rdb_s9;

endmodule

/* sv/pub_blend.sv */
// ----------------------------------------------------------------------------
// pub_blend
// Stages 10-12: neighbor routing, bilinear weights, per-channel products,
// sum with rounding and clamp; stage 12 is the output register.
// ----------------------------------------------------------------------------
module pub_blend import pub_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  blend_in_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_item
);

	logic [3:1] v_q;
	logic [4:1] en;

	logic [3:0][PIX_W-1:0]   pix_s10;
	logic [3:0][W_W-1:0]     w_s10;
	logic [PIX_W-1:0]        near_s10, near_s11, near_s12;
	logic                    nv_s10, nv_s11, nv_s12, bv_s10, bv_s11, bv_s12;
	logic [2:0][3:0][31:0]   prod_s11;
	logic [PIX_W-1:0]        bil_s12;

	logic                    dxnz, dynz;
	logic [PIX_W-1:0]        tl, tr, bl, br;
	logic [FB:0]             wx0, wx1, wy0, wy1;
	logic [2:0][7:0]         chan;

	assign dxnz = in_item.dx != '0;
	assign dynz = in_item.dy != '0;
	assign tl   = in_item.rda[{in_item.cx0, in_item.cy0}];
	assign tr   = dxnz ? in_item.rda[{~in_item.cx0, in_item.cy0}] : tl;
	assign bl   = dynz ? in_item.rda[{in_item.cx0, ~in_item.cy0}] : tl;
	assign br   = dxnz ? (dynz ? in_item.rda[{~in_item.cx0, ~in_item.cy0}] : tr) : bl;
	assign wx0  = (FB + 1)'(1 << FB) - {1'b0, in_item.dx};
	assign wx1  = {1'b0, in_item.dx};
	assign wy0  = (FB + 1)'(1 << FB) - {1'b0, in_item.dy};
	assign wy1  = {1'b0, in_item.dy};

	always_comb begin
		en[4] = out_ready;
		for (int k = 3; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= in_valid;
			if (en[2]) v_q[2] <= v_q[1];
			if (en[3]) v_q[3] <= v_q[2];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [33:0] sum;
			logic [9:0]  q;
			sum = 34'(prod_s11[c][0]) + 34'(prod_s11[c][1]) + 34'(prod_s11[c][2])
			    + 34'(prod_s11[c][3]) + 34'(1 << (2 * FB - 1));
			q = sum[2*FB+9:2*FB];
			chan[c] = (q > 10'd255) ? 8'd255 : q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pix_s10  <= {br, bl, tr, tl};
			w_s10[0] <= W_W'(wx0 * wy0);
			w_s10[1] <= W_W'(wx1 * wy0);
			w_s10[2] <= W_W'(wx0 * wy1);
			w_s10[3] <= W_W'(wx1 * wy1);
			near_s10 <= in_item.nvalid ? in_item.rdb[{in_item.nr0, in_item.nc0}] : '0;
			nv_s10   <= in_item.nvalid;
			bv_s10   <= in_item.bvalid;
		end
		if (en[2]) begin
			for (int c = 0; c < 3; c++)
				for (int n = 0; n < 4; n++)
					prod_s11[c][n] <= 32'(pix_s10[n][16-8*c +: 8]) * 32'(w_s10[n]);
			near_s11 <= near_s10;
			nv_s11   <= nv_s10;
			bv_s11   <= bv_s10;
		end
		if (en[3]) begin
			bil_s12  <= bv_s11 ? {chan[0], chan[1], chan[2]} : '0;
			near_s12 <= near_s11;
			nv_s12   <= nv_s11;
			bv_s12   <= bv_s11;
		end
	end

	assign out_valid          = v_q[3];
	assign out_item.nvalid    = nv_s12;
	assign out_item.bvalid    = bv_s12;
	assign out_item.near_pix  = near_s12;
	assign out_item.bilin_pix = bil_s12;

endmodule

/* tb/sv/tb_polar_unwrap_bilinear_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polar_unwrap_bilinear_unit
// Sends loads and panorama queries across several ring radius settings; each
// query is preceded by loads of the source pixels it samples. A sampling model
// in the bench predicts every result, and each result beat is compared with it.
// ----------------------------------------------------------------------------
module tb_polar_unwrap_bilinear_unit;
	import pub_pkg::*;

	localparam int SIDE_PX   = 2 * RADIUS_CAP;
	localparam int STORE_N   = SIDE_PX * SIDE_PX;
	localparam int LAT_WAIT  = 16;
	localparam int DOG_LIMIT = 20000;
	localparam longint ONE   = longint'(1) << FB;

	typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_e;

	typedef struct packed {
		logic       nvalid;
		logic       bvalid;
		logic [7:0] n_red;
		logic [7:0] n_green;
		logic [7:0] n_blue;
		logic [7:0] b_red;
		logic [7:0] b_green;
		logic [7:0] b_blue;
	} sample_t;

	typedef struct {
		bit     nv;
		bit     bv;
		longint nr;
		longint nc;
		longint cx;
		longint cy;
		longint cx1;
		longint cy1;
		longint dx;
		longint dy;
	} geom_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             ring_radius_we = 1'b0;
	logic [RAD_W-1:0] ring_radius_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [63:0]      s_axis_tdata = '0;
	logic [0:0]       s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [47:0]      m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	logic [23:0]      frame_px [STORE_N];
	bit               px_written [STORE_N];
	longint           quarter_tab [1025];
	logic [RAD_W-1:0] radius_reg = RAD_W'(256);
	sample_t          expected_q [$];
	int               mismatches = 0;
	int               dog = 0;
	bit               src_idle_en = 1'b1;
	bit               snk_idle_en = 1'b1;
	bit               hold_req = 1'b0;
	int               hold_cnt = 0;
	int               snk_burst = 0;

	polar_unwrap_bilinear_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.ring_radius_we(ring_radius_we), .ring_radius_wdata(ring_radius_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint quarter_amp(int k);
		longint x, t, acc;
		x = longint'(k) * 64'sd1686629713 / 1024;
		t = x;
		acc = x;
		for (int n = 1; n <= 7; n++) begin
			t = t * x / 64'sd1073741824;
			t = t * x / 64'sd1073741824;
			t = -t / longint'((2 * n) * (2 * n + 1));
			acc += t;
		end
		if (acc < 0)
			acc = 0;
		acc = (acc + (longint'(1) << (29 - FB))) >>> (30 - FB);
		if (acc > ONE)
			acc = ONE;
		return acc;
	endfunction

	function automatic longint phase_sine(int ph);
		int quad, k;
		longint v;
		quad = (ph >> 10) & 3;
		k = ph & 1023;
		v = (quad & 1) ? quarter_tab[1024 - k] : quarter_tab[k];
		return (quad & 2) ? -v : v;
	endfunction

	function automatic longint div_floor(longint v);
		return v >= 0 ? v / ONE : -((-v + ONE - 1) / ONE);
	endfunction

	function automatic longint div_round(longint v);
		return v >= 0 ? (v + ONE / 2) / ONE : -((-v + ONE / 2) / ONE);
	endfunction

	function automatic logic [23:0] px_at(longint row, longint col);
		return frame_px[row * SIDE_PX + col];
	endfunction

	function automatic geom_t query_geom(logic [7:0] orow, logic [9:0] ocol);
		geom_t  g;
		longint rad, r, cs, sn, vx, vy, fx, fy;
		int     ph;
		rad = radius_reg;
		if (rad < 1)
			rad = 1;
		if (rad > RADIUS_CAP)
			rad = RADIUS_CAP;
		r = rad - longint'(orow);
		ph = int'(((longint'(ocol) * 4096 + 2 * rad) / (4 * rad)) & 4095);
		cs = phase_sine((ph + 1024) & 4095);
		sn = phase_sine(ph);
		vx = r * cs;
		vy = r * sn;
		g.nr = rad + div_round(vx);
		g.nc = rad + div_round(vy);
		g.nv = g.nr >= 0 && g.nr < 2 * rad && g.nc >= 0 && g.nc < 2 * rad;
		fx = rad * ONE + vx;
		fy = rad * ONE + vy;
		g.cx = div_floor(fx);
		g.cy = div_floor(fy);
		g.dx = fx - g.cx * ONE;
		g.dy = fy - g.cy * ONE;
		g.cx1 = g.cx + (g.dx != 0);
		g.cy1 = g.cy + (g.dy != 0);
		g.bv = g.cx >= 0 && g.cy >= 0 && g.cx1 < 2 * rad && g.cy1 < 2 * rad;
		return g;
	endfunction

	function automatic sample_t unwrap_sample(logic [7:0] orow, logic [9:0] ocol);
		sample_t s;
		geom_t g;
		longint acc;
		logic [23:0] tl, tr, bl, br;
		logic [7:0] ch [3];
		g = query_geom(orow, ocol);
		s = '0;
		if (g.nv) begin
			s.nvalid = 1'b1;
			{s.n_red, s.n_green, s.n_blue} = px_at(g.nr, g.nc);
		end
		if (g.bv) begin
			tl = px_at(g.cx, g.cy);
			tr = px_at(g.cx1, g.cy);
			bl = px_at(g.cx, g.cy1);
			br = px_at(g.cx1, g.cy1);
			for (int i = 0; i < 3; i++) begin
				acc = longint'(tl[16-8*i +: 8]) * (ONE - g.dx) * (ONE - g.dy)
					+ longint'(tr[16-8*i +: 8]) * g.dx * (ONE - g.dy)
					+ longint'(bl[16-8*i +: 8]) * (ONE - g.dx) * g.dy
					+ longint'(br[16-8*i +: 8]) * g.dx * g.dy;
				acc = (acc + (longint'(1) << (2 * FB - 1))) >>> (2 * FB);
				ch[i] = acc > 255 ? 8'd255 : acc[7:0];
			end
			s.bvalid = 1'b1;
			s.b_red = ch[0];
			s.b_green = ch[1];
			s.b_blue = ch[2];
		end
		return s;
	endfunction

	task automatic send_beat(op_e op, logic [8:0] row, logic [8:0] col, logic [23:0] pix,
			logic [7:0] orow, logic [9:0] ocol);
		int gap;
		if (src_idle_en && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, ocol, orow, pix[7:0], pix[15:8], pix[23:16], col, row};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LOAD) begin
			frame_px[int'(row) * SIDE_PX + int'(col)] = pix;
			px_written[int'(row) * SIDE_PX + int'(col)] = 1'b1;
		end else begin
			expected_q.push_back(unwrap_sample(orow, ocol));
		end
	endtask

	task automatic send_load(logic [8:0] row, logic [8:0] col, logic [23:0] pix);
		send_beat(OP_LOAD, row, col, pix, 8'($urandom), 10'($urandom));
	endtask

	task automatic cover_px(longint row, longint col);
		if (!px_written[row * SIDE_PX + col])
			send_load(9'(row), 9'(col), 24'($urandom));
	endtask

	task automatic send_query(logic [7:0] orow, logic [9:0] ocol);
		geom_t g;
		g = query_geom(orow, ocol);
		if (g.nv)
			cover_px(g.nr, g.nc);
		if (g.bv) begin
			cover_px(g.cx, g.cy);
			cover_px(g.cx1, g.cy);
			cover_px(g.cx, g.cy1);
			cover_px(g.cx1, g.cy1);
		end
		send_beat(OP_QUERY, 9'($urandom), 9'($urandom), 24'($urandom), orow, ocol);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	task automatic set_radius(logic [RAD_W-1:0] v);
		drain_results();
		ring_radius_we <= 1'b1;
		ring_radius_wdata <= v;
		@(posedge clk);
		ring_radius_we <= 1'b0;
		radius_reg = v;
	endtask

	task automatic random_mix(int n);
		int rad;
		logic [7:0] orow;
		logic [9:0] ocol;
		rad = radius_reg == 0 ? 1
			: (int'(radius_reg) > RADIUS_CAP ? RADIUS_CAP : int'(radius_reg));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				send_load(9'($urandom), 9'($urandom), 24'($urandom));
			end else begin
				orow = $urandom_range(0, 3) != 0 ? 8'($urandom_range(0, rad - 1)) : 8'($urandom);
				ocol = $urandom_range(0, 3) != 0 ? 10'($urandom_range(0, 4 * rad - 1))
					: 10'($urandom);
				send_query(orow, ocol);
			end
		end
	endtask

	task automatic test_directed_extremes();
		send_load(9'd0, 9'd0, 24'h000000);
		send_load(9'd511, 9'd511, 24'hFFFFFF);
		send_load(9'd256, 9'd256, 24'hFF00FF);
		send_query(8'd0, 10'd0);
		send_query(8'd0, 10'd256);
		send_query(8'd0, 10'd512);
		send_query(8'd0, 10'd768);
		send_query(8'd0, 10'd1023);
		send_query(8'd255, 10'd0);
		send_query(8'd255, 10'd512);
		send_query(8'd128, 10'd100);
		send_query(8'd1, 10'd129);
		set_radius(RAD_W'(1));
		send_query(8'd0, 10'd0);
		send_query(8'd0, 10'd3);
		send_query(8'd255, 10'd1);
		send_query(8'd1, 10'd4);
		send_query(8'd255, 10'd1023);
		set_radius(RAD_W'(0));
		send_query(8'd0, 10'd2);
		send_query(8'd200, 10'd777);
		set_radius(RAD_W'(511));
		send_query(8'd0, 10'd1023);
		send_query(8'd255, 10'd333);
	endtask

	task automatic test_radius_sweep();
		logic [RAD_W-1:0] radii [10] = '{9'd2, 9'd3, 9'd7, 9'd16, 9'd100, 9'd255,
			9'd256, 9'd300, 9'd1, 9'd0};
		foreach (radii[i]) begin
			set_radius(radii[i]);
			random_mix(18);
		end
		set_radius(9'($urandom_range(1, 511)));
		random_mix(18);
	endtask

	task automatic test_backpressure();
		set_radius(RAD_W'(64));
		hold_req = 1'b1;
		random_mix(40);
	endtask

	task automatic test_drain_pause();
		random_mix(12);
		drain_results();
		random_mix(12);
	endtask

	task automatic test_streaming_tail();
		set_radius(RAD_W'(256));
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		random_mix(50);
		s_axis_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (snk_burst > 0) begin
			snk_burst--;
			m_axis_tready <= 1'b0;
		end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
			snk_burst = $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sample_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[7:0], m_axis_tdata[15:8],
				m_axis_tdata[23:16], m_axis_tdata[31:24], m_axis_tdata[39:32],
				m_axis_tdata[47:40]};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got.nvalid !== want.nvalid || got.bvalid !== want.bvalid
						|| got.n_red !== want.n_red || got.n_green !== want.n_green
						|| got.n_blue !== want.n_blue || got.b_red !== want.b_red
						|| got.b_green !== want.b_green || got.b_blue !== want.b_blue) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected nv=%b bv=%b near=%h%h%h bilin=%h%h%h",
							want.nvalid, want.bvalid, want.n_red, want.n_green, want.n_blue,
							want.b_red, want.b_green, want.b_blue);
						$display("          got      nv=%b bv=%b near=%h%h%h bilin=%h%h%h",
							got.nvalid, got.bvalid, got.n_red, got.n_green, got.n_blue,
							got.b_red, got.b_green, got.b_blue);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				dog = 0;
			else
				dog++;
			if (dog >= DOG_LIMIT) begin
				$display("** polar_unwrap_bilinear_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		for (int k = 0; k <= 1024; k++)
			quarter_tab[k] = quarter_amp(k);
		foreach (frame_px[i])
			frame_px[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_radius_sweep();
		test_backpressure();
		test_drain_pause();
		test_streaming_tail();
		drain_results();
		if (expected_q.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("** polar_unwrap_bilinear_unit: PASSED **");
		else
			$display("** polar_unwrap_bilinear_unit: FAILED **");
		$finish;
	end

endmodule
